// ----- hw/rtl/drsq_pkg.sv -----
// Shared types and constants for the depth-sorted render queue.
package drsq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned DEPTH_W = 16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic STAT_DRAINED = 1'b0;
  localparam logic STAT_DROPPED = 1'b1;

  typedef struct packed {
    logic                      valid;
    logic signed [DEPTH_W-1:0] depth;
    logic [TAG_W-1:0]          tag;
    logic                      fixed;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic drain;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

endpackage

// ----- hw/rtl/depth_sorted_render_queue.sv -----
// Top level of the depth-sorted render queue: cell chain, drain control, output register.
//
// Entries live in a chain of QUEUE_DEPTH cells kept in descending depth order, ties in
// arrival order. An insert beat is compared against every cell at once, so inserts may
// come every cycle while the input is not stalled; an insert into a full queue yields one
// result beat with status set. A flush beat drains the chain through cell 0 at one
// entry per cycle while the output side takes beats, and holds the input stalled until
// the last entry has left; a flush of an empty queue yields nothing.
module depth_sorted_render_queue #(
  parameter int unsigned QUEUE_DEPTH = drsq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic [drsq_pkg::TAG_W-1:0]           object_tag,
  input  logic signed [drsq_pkg::DEPTH_W-1:0]  object_depth,
  input  logic                                 screen_fixed,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [drsq_pkg::TAG_W-1:0]           out_tag,
  output logic signed [drsq_pkg::DEPTH_W-1:0]  out_depth,
  output logic                                 enter_world,
  output logic                                 leave_world_before,
  output logic                                 leave_world_after,
  output logic                                 status,
  output logic                                 last
);

  drsq_pkg::entry_t     cells [QUEUE_DEPTH];
  logic                 keeps [QUEUE_DEPTH];
  drsq_pkg::entry_t     new_item;
  drsq_pkg::cell_ctrl_t ctrl;
  drsq_pkg::state_t     state;
  drsq_pkg::state_t     state_next;
  logic                 prev_fixed;
  logic                 in_ok;
  logic                 out_free;
  logic                 full;
  logic                 drop;
  logic                 flush_start;
  logic                 head_last;

  assign new_item = '{valid: 1'b1, depth: object_depth, tag: object_tag,
                      fixed: screen_fixed};

  assign full      = cells[QUEUE_DEPTH-1].valid;
  assign head_last = !cells[1].valid;
  assign out_free  = !out_valid || !out_stall;
  assign in_ok     = in_valid && !in_stall;
  assign drop      = in_ok && (kind == drsq_pkg::KIND_INSERT) && full;
  assign flush_start = in_ok && (kind == drsq_pkg::KIND_FLUSH) && cells[0].valid;

  always_comb begin
    unique case (state)
      drsq_pkg::ST_IDLE: begin
        state_next = flush_start ? drsq_pkg::ST_DRAIN : drsq_pkg::ST_IDLE;
      end
      drsq_pkg::ST_DRAIN: begin
        state_next = (out_free && head_last) ? drsq_pkg::ST_IDLE : drsq_pkg::ST_DRAIN;
      end
      default: begin
        state_next = drsq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_stall = !out_free;
    unique case (state)
      drsq_pkg::ST_IDLE: begin
        ctrl.ins = in_ok && (kind == drsq_pkg::KIND_INSERT) && !full;
      end
      drsq_pkg::ST_DRAIN: begin
        in_stall = 1'b1;
        ctrl.drain = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drsq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    drsq_pkg::entry_t left;
    drsq_pkg::entry_t right;
    logic             left_keep;
    if (i == 0) begin : g_head
      assign left = '0;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left = cells[i-1];
      assign left_keep = keeps[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = cells[i+1];
    end
    drsq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_item  (new_item),
      .left      (left),
      .left_keep (left_keep),
      .right     (right),
      .entry     (cells[i]),
      .keep      (keeps[i])
    );
  end

  always_ff @(posedge clk) begin
    if (flush_start) begin
      prev_fixed <= 1'b1;
    end else if (ctrl.drain) begin
      prev_fixed <= cells[0].fixed;
    end
  end

  always_ff @(posedge clk) begin
    if (drop) begin
      out_tag            <= object_tag;
      out_depth          <= object_depth;
      enter_world        <= 1'b0;
      leave_world_before <= 1'b0;
      leave_world_after  <= 1'b0;
      status             <= drsq_pkg::STAT_DROPPED;
      last               <= 1'b0;
    end else if (ctrl.drain) begin
      out_tag            <= cells[0].tag;
      out_depth          <= cells[0].depth;
      enter_world        <= prev_fixed && !cells[0].fixed;
      leave_world_before <= !prev_fixed && cells[0].fixed;
      leave_world_after  <= head_last && !cells[0].fixed;
      status             <= drsq_pkg::STAT_DRAINED;
      last               <= head_last;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drop || ctrl.drain) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_drain_has_head: assert property (@(posedge clk) disable iff (rst)
    (state == drsq_pkg::ST_DRAIN) |-> cells[0].valid)
    else $error("drain with empty head cell");

  a_insert_fills_head: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> cells[0].valid)
    else $error("insert left head cell empty");

  a_drain_ends_empty: assert property (@(posedge clk) disable iff (rst)
    (ctrl.drain && head_last) |=> (state == drsq_pkg::ST_IDLE) && !cells[0].valid)
    else $error("queue not empty after final drain beat");

  a_full_contiguous: assert property (@(posedge clk) disable iff (rst)
    full |-> cells[0].valid)
    else $error("tail cell valid with empty head");

endmodule

// ----- hw/rtl/drsq_cell.sv -----
// One slot of the sorted chain: holds, takes the new item, or shifts from a neighbor.
module drsq_cell (
  input  logic                clk,
  input  logic                rst,
  input  drsq_pkg::cell_ctrl_t ctrl,
  input  drsq_pkg::entry_t    new_item,
  input  drsq_pkg::entry_t    left,
  input  logic                left_keep,
  input  drsq_pkg::entry_t    right,
  output drsq_pkg::entry_t    entry,
  output logic                keep
);

  drsq_pkg::entry_t entry_next;

  // stays in place on insert when valid and new depth is not above ours
  assign keep = entry.valid && (new_item.depth <= entry.depth);

  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (!keep) begin
        if (left_keep) begin
          entry_next = new_item;
        end else begin
          entry_next = left;
        end
      end
    end else if (ctrl.drain) begin
      entry_next = right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule
